@@ sv/pas_pkg.sv @@
package pas_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TAG_W       = 8;
   localparam int SIZE_BITS   = 48;
   localparam int RESV_W      = SIZE_BITS + 5;
   localparam int ACT_W       = 5;
   localparam int OP_W        = 3;
   localparam int KIND_W      = 3;
   localparam int CSR_IDX_W   = 1;

   // input operations
   localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
   localparam logic [OP_W-1:0] OP_DEMAND   = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_DONE = 3'd2;
   localparam logic [OP_W-1:0] OP_TAKEN    = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE  = 3'd4;
   localparam logic [OP_W-1:0] OP_START    = 3'd5;
   localparam logic [OP_W-1:0] OP_STOP     = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] K_DISPATCH   = 3'd0;
   localparam logic [KIND_W-1:0] K_ACCEPTED   = 3'd1;
   localparam logic [KIND_W-1:0] K_NOT_FOUND  = 3'd2;
   localparam logic [KIND_W-1:0] K_CANCELED   = 3'd3;
   localparam logic [KIND_W-1:0] K_DUPLICATE  = 3'd4;
   localparam logic [KIND_W-1:0] K_REJECTED   = 3'd5;
   localparam logic [KIND_W-1:0] K_TABLE_FULL = 3'd6;
   localparam logic [KIND_W-1:0] K_FINISHED   = 3'd7;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACTIVE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES  = 1'd1;

endpackage

@@ sv/prefetch_admission_scheduler_core.sv @@
// Prefetch admission scheduler.
// req_ channel: one command item (op, job_id, byte_count, load_failed) per
// handshake. rsp_ channel: zero to TABLE_DEPTH+1 result items per command,
// rsp_last marks the final one. csr_ channel: writes max_active (index 0) or
// max_ready_bytes (index 1); it is always ready. It is to be used only while
// idle; the block itself does not enforce this. Job tags live in flip-flops
// and are matched combinationally; job sizes and the waiting list live in two
// single-port-write RAMs with registered reads. A scheduling pass visits each
// waiting entry in S_PASS_RD and S_PASS_SZ, and S_PASS_DEC when it is examined
// fully, scanning the list at most twice; a compaction sweep through S_CMP_RD
// and S_CMP_WR per entry follows. These RAM read round trips set the rate.
// One command is handled at a time; req_ready is high only when idle.
// A staging register holds the newest result so rsp_last can be set; a
// stalled receiver just holds the sequencer at its next result.
// Reset (synchronous) empties the table, disables and un-halts the
// scheduler and sets both limits to 1. No clearing pass is needed.
module prefetch_admission_scheduler_core import pas_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OP_W-1:0]        req_op,
   input  logic [TAG_W-1:0]       req_job_id,
   input  logic [SIZE_BITS-1:0]   req_byte_count,
   input  logic                   req_load_failed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [TAG_W-1:0]       rsp_job_id_res,
   output logic [SIZE_BITS-1:0]   rsp_byte_count_res,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [SIZE_BITS-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_EXEC, S_PASS_RD, S_PASS_SZ, S_PASS_DEC,
      S_CMP_RD, S_CMP_WR, S_STOP_RD, S_STOP_SZ, S_STOP_EMIT, S_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic [SIZE_BITS-1:0]    bytes_ff, bytes_in;
   logic                    failed_ff, failed_in;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic                    free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0]  dem_ff, dem_in;
   logic [TABLE_DEPTH-1:0]  disp_ff, disp_in;
   logic [TAG_W-1:0]        slot_tag_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]        wcnt_ff, wcnt_in;
   logic [ACT_W-1:0]        infl_ff, infl_in;
   logic [RESV_W-1:0]       resv_ff, resv_in;
   logic                    en_ff, en_in;
   logic                    halt_ff, halt_in;
   logic [ACT_W-1:0]        max_act_ff, max_act_in;
   logic [SIZE_BITS-1:0]    max_bytes_ff, max_bytes_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        kcnt_ff, kcnt_in;
   logic                    scan2_ff, scan2_in;
   logic                    cmp_all_ff, cmp_all_in;
   logic [IDX_W-1:0]        cur_s_ff, cur_s_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [KIND_W-1:0]       pend_kind_ff, pend_kind_in;
   logic [TAG_W-1:0]        pend_tag_ff, pend_tag_in;
   logic [SIZE_BITS-1:0]    pend_bytes_ff, pend_bytes_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic [SIZE_BITS-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memories and their ports
   logic [SIZE_BITS-1:0]    size_mem [TABLE_DEPTH];
   logic [IDX_W-1:0]        order_mem [TABLE_DEPTH];
   logic [SIZE_BITS-1:0]    size_rd_ff;
   logic [IDX_W-1:0]        ord_rd_ff;
   logic                    size_re, size_we, ord_re, ord_we, tag_we;
   logic [IDX_W-1:0]        size_raddr, size_waddr, ord_raddr, ord_waddr, ord_wdata;

   // combinational helpers
   logic                    look_hit, look_free;
   logic [IDX_W-1:0]        look_hit_idx, look_free_idx;
   logic                    out_free, can_emit, emit_req, emit_go;
   logic [KIND_W-1:0]       emit_kind;
   logic [TAG_W-1:0]       emit_tag;
   logic [SIZE_BITS-1:0]    emit_bytes;
   logic [ACT_W-1:0]        limit;
   logic [SIZE_BITS-1:0]    budget;
   logic [RESV_W-1:0]       budget_ext, size_ext, room;
   logic                    fits;
   logic [RESV_W:0]         resv_sum;
   logic                    pass_on;
   logic                    drop;

   assign req_ready          = (state_ff == S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_job_id_res     = rsp_tag_ff;
   assign rsp_byte_count_res = rsp_bytes_ff;
   assign rsp_last           = rsp_last_ff;

   // tag match and free slot search over the tag flops
   always_comb begin
      look_hit      = 1'b0;
      look_hit_idx  = '0;
      look_free     = 1'b0;
      look_free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (valid_ff[i] && slot_tag_ff[i] == tag_ff) begin
            look_hit     = 1'b1;
            look_hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            look_free     = 1'b1;
            look_free_idx = IDX_W'(i);
         end
      end
   end

   // budget check for the slot under examination
   assign limit      = (max_act_ff == '0) ? ACT_W'(1) : max_act_ff;
   assign budget     = (max_bytes_ff == '0) ? SIZE_BITS'(1) : max_bytes_ff;
   assign budget_ext = RESV_W'(budget);
   assign size_ext   = RESV_W'(size_rd_ff);
   assign room       = budget_ext - resv_ff;
   assign fits       = (resv_ff <= budget_ext) && (size_ext <= room);
   assign resv_sum   = {1'b0, resv_ff} + (RESV_W + 1)'(size_rd_ff);
   assign pass_on    = en_ff && !halt_ff;
   assign drop       = cmp_all_ff ? disp_ff[ord_rd_ff] : (ord_rd_ff == hit_idx_ff);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_emit = !pend_valid_ff || out_free;
   assign emit_go  = emit_req && can_emit;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      bytes_in      = bytes_ff;
      failed_in     = failed_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      dem_in        = dem_ff;
      disp_in       = disp_ff;
      wcnt_in       = wcnt_ff;
      infl_in       = infl_ff;
      resv_in       = resv_ff;
      en_in         = en_ff;
      halt_in       = halt_ff;
      max_act_in    = max_act_ff;
      max_bytes_in  = max_bytes_ff;
      idx_in        = idx_ff;
      kcnt_in       = kcnt_ff;
      scan2_in      = scan2_ff;
      cmp_all_in    = cmp_all_ff;
      cur_s_in      = cur_s_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_tag_in   = pend_tag_ff;
      pend_bytes_in = pend_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_last_in   = rsp_last_ff;
      emit_req      = 1'b0;
      emit_kind     = K_ACCEPTED;
      emit_tag      = tag_ff;
      emit_bytes    = '0;
      size_re       = 1'b0;
      size_raddr    = hit_idx_ff;
      size_we       = 1'b0;
      size_waddr    = free_idx_ff;
      ord_re        = 1'b0;
      ord_raddr     = idx_ff[IDX_W-1:0];
      ord_we        = 1'b0;
      ord_waddr     = wcnt_ff[IDX_W-1:0];
      ord_wdata     = free_idx_ff;
      tag_we        = 1'b0;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_ACTIVE: max_act_in   = csr_wdata[ACT_W-1:0];
            CSR_MAX_BYTES:  max_bytes_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               tag_in    = req_job_id;
               bytes_in  = req_byte_count;
               failed_in = req_load_failed;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            hit_in      = look_hit;
            hit_idx_in  = look_hit_idx;
            free_ok_in  = look_free;
            free_idx_in = look_free_idx;
            size_re     = 1'b1;
            size_raddr  = look_hit_idx;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            idx_in   = '0;
            scan2_in = 1'b0;
            case (op_ff)
               OP_REGISTER: begin
                  emit_req = 1'b1;
                  if (halt_ff) begin
                     emit_kind = K_REJECTED;
                     if (emit_go) state_in = S_FLUSH;
                  end else if (hit_ff) begin
                     emit_kind = K_DUPLICATE;
                     if (emit_go) state_in = S_FLUSH;
                  end else if (!free_ok_ff || wcnt_ff >= CNT_W'(TABLE_DEPTH)) begin
                     emit_kind = K_TABLE_FULL;
                     if (emit_go) state_in = S_FLUSH;
                  end else begin
                     emit_kind  = K_ACCEPTED;
                     emit_bytes = bytes_ff;
                     if (emit_go) begin
                        valid_in[free_idx_ff] = 1'b1;
                        dem_in[free_idx_ff]   = 1'b0;
                        disp_in[free_idx_ff]  = 1'b0;
                        tag_we   = 1'b1;
                        size_we  = 1'b1;
                        ord_we   = 1'b1;
                        wcnt_in  = wcnt_ff + CNT_W'(1);
                        state_in = S_PASS_RD;
                     end
                  end
               end
               OP_DEMAND: begin
                  emit_req = 1'b1;
                  if (!hit_ff) begin
                     emit_kind = K_NOT_FOUND;
                     if (emit_go) state_in = S_FLUSH;
                  end else begin
                     emit_kind  = K_ACCEPTED;
                     emit_bytes = size_rd_ff;
                     if (emit_go) begin
                        dem_in[hit_idx_ff] = 1'b1;
                        state_in = S_PASS_RD;
                     end
                  end
               end
               OP_LOAD_DONE: begin
                  emit_req = 1'b1;
                  if (!hit_ff || !disp_ff[hit_idx_ff]) begin
                     emit_kind = K_NOT_FOUND;
                     if (emit_go) state_in = S_FLUSH;
                  end else begin
                     emit_kind  = K_FINISHED;
                     emit_bytes = size_rd_ff;
                     if (emit_go) begin
                        if (infl_ff != '0) infl_in = infl_ff - ACT_W'(1);
                        if (failed_ff)
                           resv_in = (resv_ff > size_ext) ? resv_ff - size_ext : '0;
                        state_in = S_PASS_RD;
                     end
                  end
               end
               OP_TAKEN: begin
                  emit_req = 1'b1;
                  if (!hit_ff) begin
                     emit_kind = K_NOT_FOUND;
                     if (emit_go) state_in = S_FLUSH;
                  end else begin
                     emit_kind  = K_ACCEPTED;
                     emit_bytes = size_rd_ff;
                     if (emit_go) begin
                        valid_in[hit_idx_ff] = 1'b0;
                        dem_in[hit_idx_ff]   = 1'b0;
                        disp_in[hit_idx_ff]  = 1'b0;
                        kcnt_in    = '0;
                        cmp_all_in = 1'b0;
                        state_in   = S_CMP_RD;
                     end
                  end
               end
               OP_RELEASE: begin
                  resv_in  = (resv_ff > RESV_W'(bytes_ff)) ? resv_ff - RESV_W'(bytes_ff) : '0;
                  state_in = S_PASS_RD;
               end
               OP_START: begin
                  if (en_ff || halt_ff) begin
                     state_in = S_FLUSH;
                  end else begin
                     en_in    = 1'b1;
                     state_in = S_PASS_RD;
                  end
               end
               OP_STOP: begin
                  if (halt_ff) begin
                     state_in = S_FLUSH;
                  end else begin
                     halt_in  = 1'b1;
                     en_in    = 1'b0;
                     state_in = S_STOP_RD;
                  end
               end
               default: state_in = S_FLUSH;
            endcase
         end
         // scan entry idx of the waiting list
         S_PASS_RD: begin
            if (!pass_on) begin
               state_in = S_FLUSH;
            end else if (infl_ff >= limit || (idx_ff >= wcnt_ff && scan2_ff)) begin
               idx_in     = '0;
               kcnt_in    = '0;
               cmp_all_in = 1'b1;
               state_in   = S_CMP_RD;
            end else if (idx_ff >= wcnt_ff) begin
               idx_in   = '0;
               scan2_in = 1'b1;
            end else begin
               ord_re   = 1'b1;
               state_in = S_PASS_SZ;
            end
         end
         S_PASS_SZ: begin
            cur_s_in = ord_rd_ff;
            if (disp_ff[ord_rd_ff] || (!scan2_ff && !dem_ff[ord_rd_ff])) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_PASS_RD;
            end else begin
               size_re    = 1'b1;
               size_raddr = ord_rd_ff;
               state_in   = S_PASS_DEC;
            end
         end
         S_PASS_DEC: begin
            if (fits || dem_ff[cur_s_ff]) begin
               emit_req   = 1'b1;
               emit_kind  = K_DISPATCH;
               emit_tag   = slot_tag_ff[cur_s_ff];
               emit_bytes = size_rd_ff;
               if (emit_go) begin
                  disp_in[cur_s_ff] = 1'b1;
                  infl_in  = infl_ff + ACT_W'(1);
                  resv_in  = resv_sum[RESV_W] ? '1 : resv_sum[RESV_W-1:0];
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_PASS_RD;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_PASS_RD;
            end
         end
         // compact the waiting list in place
         S_CMP_RD: begin
            if (idx_ff >= wcnt_ff) begin
               wcnt_in  = kcnt_ff;
               state_in = S_FLUSH;
            end else begin
               ord_re   = 1'b1;
               state_in = S_CMP_WR;
            end
         end
         S_CMP_WR: begin
            if (!drop) begin
               ord_we    = 1'b1;
               ord_waddr = kcnt_ff[IDX_W-1:0];
               ord_wdata = ord_rd_ff;
               kcnt_in   = kcnt_ff + CNT_W'(1);
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_CMP_RD;
         end
         // cancel every waiting job that is not yet dispatched
         S_STOP_RD: begin
            if (idx_ff >= wcnt_ff) begin
               wcnt_in  = '0;
               state_in = S_FLUSH;
            end else begin
               ord_re   = 1'b1;
               state_in = S_STOP_SZ;
            end
         end
         S_STOP_SZ: begin
            cur_s_in = ord_rd_ff;
            if (disp_ff[ord_rd_ff]) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_STOP_RD;
            end else begin
               size_re    = 1'b1;
               size_raddr = ord_rd_ff;
               state_in   = S_STOP_EMIT;
            end
         end
         S_STOP_EMIT: begin
            emit_req   = 1'b1;
            emit_kind  = K_CANCELED;
            emit_tag   = slot_tag_ff[cur_s_ff];
            emit_bytes = size_rd_ff;
            if (emit_go) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_STOP_RD;
            end
         end
         // push out the staged result with the last flag
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_tag_in    = pend_tag_ff;
               rsp_bytes_in  = pend_bytes_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // new result: the staged one moves to the output, the new one is staged
      if (emit_go) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = pend_kind_ff;
            rsp_tag_in   = pend_tag_ff;
            rsp_bytes_in = pend_bytes_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_kind_in  = emit_kind;
         pend_tag_in   = emit_tag;
         pend_bytes_in = emit_bytes;
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         dem_ff        <= '0;
         disp_ff       <= '0;
         wcnt_ff       <= '0;
         infl_ff       <= '0;
         resv_ff       <= '0;
         en_ff         <= 1'b0;
         halt_ff       <= 1'b0;
         max_act_ff    <= ACT_W'(1);
         max_bytes_ff  <= SIZE_BITS'(1);
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         dem_ff        <= dem_in;
         disp_ff       <= disp_in;
         wcnt_ff       <= wcnt_in;
         infl_ff       <= infl_in;
         resv_ff       <= resv_in;
         en_ff         <= en_in;
         halt_ff       <= halt_in;
         max_act_ff    <= max_act_in;
         max_bytes_ff  <= max_bytes_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      bytes_ff      <= bytes_in;
      failed_ff     <= failed_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      idx_ff        <= idx_in;
      kcnt_ff       <= kcnt_in;
      scan2_ff      <= scan2_in;
      cmp_all_ff    <= cmp_all_in;
      cur_s_ff      <= cur_s_in;
      pend_kind_ff  <= pend_kind_in;
      pend_tag_ff   <= pend_tag_in;
      pend_bytes_ff <= pend_bytes_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_last_ff   <= rsp_last_in;
      if (tag_we) slot_tag_ff[free_idx_ff] <= tag_ff;
   end

   // job size RAM
   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_waddr] <= bytes_ff;
      if (size_re) size_rd_ff <= size_mem[size_raddr];
   end

   // waiting list RAM
   always_ff @(posedge clock) begin
      if (ord_we) order_mem[ord_waddr] <= ord_wdata;
      if (ord_re) ord_rd_ff <= order_mem[ord_raddr];
   end

   // checks
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("waiting count above table depth");

   a_disp_subset: assert property (@(posedge clock) disable iff (reset)
      (disp_ff & ~valid_ff) == '0)
      else $error("dispatched flag on a free slot");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("staged item left behind when idle");

   a_halt_off: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !en_ff)
      else $error("enabled while halted");

endmodule
